FILE: rtl/core/icp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icp_pkg;
    localparam int LANES = 5;
    localparam int VALUE_W = 32;
    localparam int LIMIT_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int PACKED_W = 64;
    localparam int POSITION_CODE_BITS_DEF = 16;
    localparam int GAIN_CODE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POS       = 3'd0,
        REG_VEL       = 3'd1,
        REG_TORQUE    = 3'd2,
        REG_STIFFNESS = 3'd3,
        REG_DAMPING   = 3'd4
    } reg_index_t;

    localparam logic [CFG_INDEX_W-1:0] LIMIT_COUNT = 3'd5;

    typedef logic [LIMIT_W-1:0] limit_t;

    function automatic limit_t limit_reset(input int idx);
        limit_t v;
        begin
            case (idx)
                int'(REG_POS): v = 64'h00008000FFFF8000;
                int'(REG_VEL): v = 64'h000A0000FFF60000;
                int'(REG_TORQUE): v = 64'h000A0000FFF60000;
                int'(REG_STIFFNESS): v = 64'h0064000000000000;
                int'(REG_DAMPING): v = 64'h0014000000000000;
                default: v = '0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/icp_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface icp_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_target;
    logic signed [31:0] vel_target;
    logic signed [31:0] torque_target;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;

    modport source (output valid, pos_target, vel_target, torque_target,
                    stiffness_gain, damping_gain, input ready);
    modport sink (input valid, pos_target, vel_target, torque_target,
                  stiffness_gain, damping_gain, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/icp_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface icp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_command;
    logic        span_fault;

    modport source (output valid, packed_command, span_fault, input ready);
    modport sink (input valid, packed_command, span_fault, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/impedance_command_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// Packs one impedance command word into a 64-bit result word each cycle. A word is
// accepted in every cycle while the result side keeps up. The restoring divider has N
// pipeline stages, where N is the wider of POSITION_CODE_BITS and GAIN_CODE_BITS, and
// resolves one code bit per stage for all five quantities at once. A four-word queue
// between the clamp and scale stages and the divider lets each side stall on its own.
// Limit registers are to be written only while idle; the block does not enforce this.
module impedance_command_packer #(
    parameter int POSITION_CODE_BITS = icp_pkg::POSITION_CODE_BITS_DEF,
    parameter int GAIN_CODE_BITS = icp_pkg::GAIN_CODE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [icp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [icp_pkg::LIMIT_W-1:0]       cfg_wdata,
    icp_cmd_if.sink                                cmd,
    icp_res_if.source                              res
);
    localparam int QB = (POSITION_CODE_BITS > GAIN_CODE_BITS) ? POSITION_CODE_BITS
                                                               : GAIN_CODE_BITS;
    localparam int PRW = icp_pkg::VALUE_W + QB;
    localparam int LW = PRW + icp_pkg::VALUE_W;
    localparam int EW = icp_pkg::LANES * LW + 1;

    icp_pkg::limit_t limit_reg [icp_pkg::LANES];
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < icp_pkg::LANES; i++)
                limit_reg[i] <= icp_pkg::limit_reset(i);
        end
        else if (cfg_we && (cfg_index < icp_pkg::LIMIT_COUNT))
        begin
            limit_reg[cfg_index] <= cfg_wdata;
        end
    end

    icp_front #(
        .POSITION_CODE_BITS(POSITION_CODE_BITS),
        .GAIN_CODE_BITS(GAIN_CODE_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .limits(limit_reg),
        .full(full),
        .push(push),
        .entry(wdata)
    );

    icp_fifo #(
        .W(EW),
        .DEPTH(icp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wdata(wdata),
        .pop(pop),
        .rdata(rdata),
        .full(full),
        .empty(empty)
    );

    icp_back #(
        .POSITION_CODE_BITS(POSITION_CODE_BITS),
        .GAIN_CODE_BITS(GAIN_CODE_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .entry(rdata),
        .empty(empty),
        .pop(pop),
        .res(res)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> !empty)
        else $error("queue lost words while stalled");
endmodule
`default_nettype wire

FILE: rtl/core/icp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module icp_front #(
    parameter int POSITION_CODE_BITS = icp_pkg::POSITION_CODE_BITS_DEF,
    parameter int GAIN_CODE_BITS = icp_pkg::GAIN_CODE_BITS_DEF,
    localparam int QB = (POSITION_CODE_BITS > GAIN_CODE_BITS) ? POSITION_CODE_BITS
                                                               : GAIN_CODE_BITS,
    localparam int PRW = icp_pkg::VALUE_W + QB,
    localparam int LW = PRW + icp_pkg::VALUE_W,
    localparam int EW = icp_pkg::LANES * LW + 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    icp_cmd_if.sink                    cmd,
    input  wire icp_pkg::limit_t       limits [icp_pkg::LANES],
    input  wire logic                  full,
    output logic                       push,
    output logic [EW-1:0]              entry
);
    localparam int VW = icp_pkg::VALUE_W;

    logic          s1_v_reg;
    logic [VW-1:0] d_reg [icp_pkg::LANES];
    logic [VW-1:0] span_reg [icp_pkg::LANES];
    logic [icp_pkg::LANES-1:0] fault_reg;
    logic          s2_v_reg;
    logic [EW-1:0] entry_reg;
    logic          s1_move;
    logic          s2_move;
    logic signed [VW-1:0] x [icp_pkg::LANES];
    logic [VW-1:0] d_next [icp_pkg::LANES];
    logic [VW-1:0] span_next [icp_pkg::LANES];
    logic [icp_pkg::LANES-1:0] fault_next;
    logic [EW-1:0] entry_next;

    assign s2_move = !s2_v_reg || !full;
    assign s1_move = !s1_v_reg || s2_move;
    assign cmd.ready = s1_move;
    assign push = s2_v_reg && !full;
    assign entry = entry_reg;

    assign x[icp_pkg::REG_POS] = cmd.pos_target;
    assign x[icp_pkg::REG_VEL] = cmd.vel_target;
    assign x[icp_pkg::REG_TORQUE] = cmd.torque_target;
    assign x[icp_pkg::REG_STIFFNESS] = cmd.stiffness_gain;
    assign x[icp_pkg::REG_DAMPING] = cmd.damping_gain;

    // Clamp to the limits and take the offset from the minimum and the span.
    always_comb
    begin
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] xc;
        logic [VW:0] diff;
        logic [VW:0] sp;
        for (int l = 0; l < icp_pkg::LANES; l++)
        begin
            lo = limits[l][VW-1:0];
            hi = limits[l][2*VW-1:VW];
            xc = (x[l] < lo) ? lo : ((x[l] > hi) ? hi : x[l]);
            diff = {xc[VW-1], xc} - {lo[VW-1], lo};
            sp = {hi[VW-1], hi} - {lo[VW-1], lo};
            d_next[l] = diff[VW-1:0];
            span_next[l] = sp[VW-1:0];
            fault_next[l] = !(hi > lo);
        end
    end

    // Scale by the full code and force a zero code where the span is bad.
    always_comb
    begin
        logic [PRW-1:0] full_code;
        logic [PRW-1:0] prod;
        entry_next = '0;
        for (int l = 0; l < icp_pkg::LANES; l++)
        begin
            if (l == int'(icp_pkg::REG_POS))
                full_code = PRW'((1 << POSITION_CODE_BITS) - 1);
            else
                full_code = PRW'((1 << GAIN_CODE_BITS) - 1);
            prod = PRW'({{QB{1'b0}}, d_reg[l]} * full_code);
            entry_next[l*LW +: PRW] = fault_reg[l] ? '0 : prod;
            entry_next[l*LW+PRW +: VW] = fault_reg[l] ? VW'(1) : span_reg[l];
        end
        entry_next[EW-1] = |fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
                s1_v_reg <= cmd.valid;
            if (s2_move)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            d_reg <= d_next;
            span_reg <= span_next;
            fault_reg <= fault_next;
        end
        if (s2_move)
            entry_reg <= entry_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/icp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module icp_fifo #(
    parameter int W = 8,
    parameter int DEPTH = icp_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              full,
    output logic              empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] count_reg;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end
endmodule
`default_nettype wire

FILE: rtl/core/icp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module icp_back #(
    parameter int POSITION_CODE_BITS = icp_pkg::POSITION_CODE_BITS_DEF,
    parameter int GAIN_CODE_BITS = icp_pkg::GAIN_CODE_BITS_DEF,
    localparam int QB = (POSITION_CODE_BITS > GAIN_CODE_BITS) ? POSITION_CODE_BITS
                                                               : GAIN_CODE_BITS,
    localparam int PRW = icp_pkg::VALUE_W + QB,
    localparam int LW = PRW + icp_pkg::VALUE_W,
    localparam int EW = icp_pkg::LANES * LW + 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [EW-1:0] entry,
    input  wire logic          empty,
    output logic               pop,
    icp_res_if.source          res
);
    localparam int VW = icp_pkg::VALUE_W;
    localparam int NS = QB;
    localparam int QW = QB;
    localparam int L = icp_pkg::LANES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] flt_reg;
    logic [PRW-1:0] rem_reg [NS][L];
    logic [VW-1:0] span_reg [NS][L];
    logic [QW-1:0] q_reg [NS][L];
    logic          out_v_reg;
    logic [icp_pkg::PACKED_W-1:0] packed_reg;
    logic          fault_out_reg;
    logic          adv;
    logic [icp_pkg::PACKED_W-1:0] packed_next;

    assign adv = !out_v_reg || res.ready;
    assign pop = adv && !empty;
    assign res.valid = out_v_reg;
    assign res.packed_command = packed_reg;
    assign res.span_fault = fault_out_reg;

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int B = QW - 1 - s;
        logic [PRW-1:0] rem_in [L];
        logic [VW-1:0] span_in [L];
        logic [QW-1:0] q_in [L];
        logic [PRW-1:0] rem_nx [L];
        logic [QW-1:0] q_nx [L];
        logic v_in;
        logic f_in;

        always_comb
        begin
            for (int l = 0; l < L; l++)
            begin
                if (s == 0)
                begin
                    rem_in[l] = entry[l*LW +: PRW];
                    span_in[l] = entry[l*LW+PRW +: VW];
                    q_in[l] = '0;
                end
                else
                begin
                    rem_in[l] = rem_reg[(s == 0) ? 0 : s-1][l];
                    span_in[l] = span_reg[(s == 0) ? 0 : s-1][l];
                    q_in[l] = q_reg[(s == 0) ? 0 : s-1][l];
                end
            end
            if (s == 0)
            begin
                v_in = !empty;
                f_in = entry[EW-1];
            end
            else
            begin
                v_in = v_reg[(s == 0) ? 0 : s-1];
                f_in = flt_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_comb
        begin
            logic [PRW-1:0] sh;
            for (int l = 0; l < L; l++)
            begin
                sh = PRW'({{QB{1'b0}}, span_in[l]}) << B;
                if (rem_in[l] >= sh)
                begin
                    rem_nx[l] = rem_in[l] - sh;
                    q_nx[l] = q_in[l] | (QW'(1) << B);
                end
                else
                begin
                    rem_nx[l] = rem_in[l];
                    q_nx[l] = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (adv)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_nx;
                span_reg[s] <= span_in;
                q_reg[s] <= q_nx;
                flt_reg[s] <= f_in;
            end
        end
    end

    // Torque at the bottom, then damping, stiffness, velocity and position.
    always_comb
    begin
        packed_next = '0;
        packed_next[0 +: GAIN_CODE_BITS] =
            q_reg[NS-1][icp_pkg::REG_TORQUE][GAIN_CODE_BITS-1:0];
        packed_next[GAIN_CODE_BITS +: GAIN_CODE_BITS] =
            q_reg[NS-1][icp_pkg::REG_DAMPING][GAIN_CODE_BITS-1:0];
        packed_next[2*GAIN_CODE_BITS +: GAIN_CODE_BITS] =
            q_reg[NS-1][icp_pkg::REG_STIFFNESS][GAIN_CODE_BITS-1:0];
        packed_next[3*GAIN_CODE_BITS +: GAIN_CODE_BITS] =
            q_reg[NS-1][icp_pkg::REG_VEL][GAIN_CODE_BITS-1:0];
        packed_next[4*GAIN_CODE_BITS +: POSITION_CODE_BITS] =
            q_reg[NS-1][icp_pkg::REG_POS][POSITION_CODE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            packed_reg <= packed_next;
            fault_out_reg <= flt_reg[NS-1];
        end
    end
endmodule
`default_nettype wire
